// ===== rtl/core/dmr_pkg.sv =====
`default_nettype none

package dmr_pkg;

    // Received packet limits
    localparam int MAX_PACKET_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HDR_BYTES        = 8;

    // Protocol constants
    localparam logic [7:0]  DOIP_VERSION = 8'h02;
    localparam logic [15:0] TYPE_RA_REQ  = 16'h0005;
    localparam logic [15:0] TYPE_RA_RES  = 16'h0006;
    localparam logic [15:0] TYPE_DIAG    = 16'h8001;
    localparam logic [7:0]  RA_SUCCESS   = 8'h10;
    localparam logic [15:0] GW_RESET     = 16'h0001;
    localparam logic [31:0] RA_RES_LEN   = 32'd9;
    localparam logic [31:0] RA_MIN_LEN   = 32'd7;
    localparam logic [31:0] DIAG_MIN_LEN = 32'd5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command kinds
    localparam logic [1:0] CMD_RA   = 2'd0;   // routing activation response
    localparam logic [1:0] CMD_HDR  = 2'd1;   // echo header plus swapped addresses
    localparam logic [1:0] CMD_BYTE = 2'd2;   // one echoed payload byte

    // Response lengths in bytes
    localparam int RA_RES_BYTES  = 17;
    localparam int ECHO_HDR_BYTES = 12;
    localparam int IDX_W         = $clog2(RA_RES_BYTES);

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       new_session;
    } t_rx_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       tx_truncated;
    } t_tx_item;

    // word_a: RA {tester, gateway}, HDR declared length
    // word_b: HDR address pair, BYTE {24'b0, byte}
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic        last;
        logic        trunc;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/dmr_front.sv =====
`default_nettype none

module dmr_front (
    input  wire                logic        i_clk,
    input  wire                logic        i_rst_n,
    input  wire                logic        i_rx_valid,
    input  wire dmr_pkg::t_rx_item          i_rx,
    output logic                            o_rx_stall,
    input  wire                logic [15:0] i_gateway,
    input  wire                logic        i_q_full,
    output logic                            o_push,
    output dmr_pkg::t_cmd                   o_cmd
);

    localparam logic [1:0] MODE_DROP = 2'd0;
    localparam logic [1:0] MODE_RA   = 2'd1;
    localparam logic [1:0] MODE_ECHO = 2'd2;

    localparam int PW = dmr_pkg::POS_W;
    localparam logic [PW-1:0] P_HDR_END  = PW'(dmr_pkg::HDR_BYTES - 1);
    localparam logic [PW-1:0] P_PAYLOAD  = PW'(dmr_pkg::HDR_BYTES);
    localparam logic [PW-1:0] P_ADDR_END = PW'(dmr_pkg::HDR_BYTES + 3);
    localparam logic [PW-1:0] P_MAX      = PW'(dmr_pkg::MAX_PACKET_BYTES);
    localparam logic [PW-1:0] P_CAP      = PW'(dmr_pkg::MAX_PACKET_BYTES - 1);

    logic [PW-1:0] r_pos,    n_pos;
    logic [1:0]    r_mode,   n_mode;
    logic          r_active, n_active;
    logic [55:0]   r_hdr,    n_hdr;
    logic [31:0]   r_len,    n_len;
    logic [31:0]   r_addr,   n_addr;

    logic          accept;
    logic [PW-1:0] pos_e;
    logic [1:0]    mode_e;
    logic [31:0]   len_now;
    logic [31:0]   addr_now;
    logic [31:0]   pay_count;
    logic          at_end;
    logic          at_cap;
    logic          close;

    assign o_rx_stall = i_q_full || !i_rst_n;
    assign accept     = i_rx_valid && !o_rx_stall;

    // A new session restarts the packet and drops activation
    assign pos_e  = i_rx.new_session ? '0 : r_pos;
    assign mode_e = i_rx.new_session ? MODE_DROP : r_mode;

    assign len_now   = {r_hdr[23:0], i_rx.rx_byte};
    assign addr_now  = {r_addr[23:0], i_rx.rx_byte};
    assign pay_count = 32'(pos_e) - 32'(P_HDR_END);
    assign at_end    = pay_count == r_len;
    assign at_cap    = pos_e == P_CAP;
    assign close     = at_end || i_rx.rx_last || at_cap;

    // Byte classification
    always_comb begin
        n_pos    = r_pos;
        n_mode   = r_mode;
        n_active = r_active;
        n_hdr    = r_hdr;
        n_len    = r_len;
        n_addr   = r_addr;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept) begin
            n_pos    = pos_e;
            n_mode   = mode_e;
            n_active = i_rx.new_session ? 1'b0 : r_active;
            if (pos_e < P_MAX) begin
                if (pos_e < P_HDR_END) begin
                    n_hdr = {r_hdr[47:0], i_rx.rx_byte};
                end else if (pos_e == P_HDR_END) begin
                    n_len  = len_now;
                    n_mode = MODE_DROP;
                    if (r_hdr[55:48] == dmr_pkg::DOIP_VERSION) begin
                        if (r_hdr[39:24] == dmr_pkg::TYPE_RA_REQ
                            && len_now >= dmr_pkg::RA_MIN_LEN) begin
                            n_mode = MODE_RA;
                        end else if (r_hdr[39:24] == dmr_pkg::TYPE_DIAG && n_active
                                     && len_now >= dmr_pkg::DIAG_MIN_LEN) begin
                            n_mode = MODE_ECHO;
                        end
                    end
                end else begin
                    unique case (mode_e)
                        MODE_RA: begin
                            if (pos_e == P_PAYLOAD) begin
                                n_addr = {24'd0, i_rx.rx_byte};
                            end else begin
                                o_push       = 1'b1;
                                o_cmd.kind   = dmr_pkg::CMD_RA;
                                o_cmd.word_a = {r_addr[7:0], i_rx.rx_byte, i_gateway};
                                n_active     = 1'b1;
                                n_mode       = MODE_DROP;
                            end
                        end
                        MODE_ECHO: begin
                            if (pos_e < P_ADDR_END) begin
                                n_addr = addr_now;
                            end else if (pos_e == P_ADDR_END) begin
                                n_addr       = addr_now;
                                o_push       = 1'b1;
                                o_cmd.kind   = dmr_pkg::CMD_HDR;
                                o_cmd.word_a = r_len;
                                o_cmd.word_b = addr_now;
                                o_cmd.last   = i_rx.rx_last;
                                o_cmd.trunc  = i_rx.rx_last;
                                if (i_rx.rx_last) begin
                                    n_mode = MODE_DROP;
                                end
                            end else begin
                                o_push       = 1'b1;
                                o_cmd.kind   = dmr_pkg::CMD_BYTE;
                                o_cmd.word_b = {24'd0, i_rx.rx_byte};
                                o_cmd.last   = close;
                                o_cmd.trunc  = close && !at_end;
                                if (close) begin
                                    n_mode = MODE_DROP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Packet bookkeeping
            if (i_rx.rx_last) begin
                n_pos  = '0;
                n_mode = MODE_DROP;
            end else if (pos_e < P_MAX) begin
                n_pos = pos_e + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_mode   <= MODE_DROP;
            r_active <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_mode   <= n_mode;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_len  <= n_len;
        r_addr <= n_addr;
    end

    // Activation only comes with a routing response
    a_active_from_ra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_active) |-> $past(o_push && o_cmd.kind == dmr_pkg::CMD_RA))
        else $error("activation set without routing response");

endmodule

`default_nettype wire

// ===== rtl/core/dmr_queue.sv =====
`default_nettype none

module dmr_queue (
    input  wire           logic i_clk,
    input  wire           logic i_rst_n,
    input  wire           logic i_push,
    input  wire dmr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire           logic i_pop,
    output logic                o_valid,
    output dmr_pkg::t_cmd       o_cmd
);

    localparam int PW = dmr_pkg::QPTR_W;
    localparam int CW = dmr_pkg::QCNT_W;
    localparam logic [CW-1:0] DEPTH = CW'(dmr_pkg::QUEUE_DEPTH);

    dmr_pkg::t_cmd r_mem [dmr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = r_count == DEPTH;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH)
        else $error("queue count beyond depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/dmr_back.sv =====
`default_nettype none

module dmr_back (
    input  wire              logic i_clk,
    input  wire              logic i_rst_n,
    input  wire              logic i_q_valid,
    input  wire dmr_pkg::t_cmd     i_cmd,
    output logic                   o_pop,
    output logic                   o_tx_valid,
    output dmr_pkg::t_tx_item      o_tx,
    input  wire              logic i_tx_stall
);

    localparam int IW = dmr_pkg::IDX_W;
    localparam logic [IW-1:0] RA_LAST   = IW'(dmr_pkg::RA_RES_BYTES - 1);
    localparam logic [IW-1:0] HDR_LAST  = IW'(dmr_pkg::ECHO_HDR_BYTES - 1);
    localparam logic [IW-1:0] HDR_END   = IW'(dmr_pkg::HDR_BYTES);

    logic [IW-1:0]     r_idx;
    logic              r_out_valid;
    dmr_pkg::t_tx_item r_out;
    dmr_pkg::t_tx_item item;
    logic              final_byte;
    logic              load;

    // Header byte of a response
    function automatic logic [7:0] hdr_byte(input logic [15:0] ptype,
                                            input logic [31:0] plen,
                                            input logic [2:0]  sel);
        logic [7:0] b;
        unique case (sel)
            3'd0:    b = dmr_pkg::DOIP_VERSION;
            3'd1:    b = ~dmr_pkg::DOIP_VERSION;
            3'd2:    b = ptype[15:8];
            3'd3:    b = ptype[7:0];
            3'd4:    b = plen[31:24];
            3'd5:    b = plen[23:16];
            3'd6:    b = plen[15:8];
            default: b = plen[7:0];
        endcase
        return b;
    endfunction

    // Byte selection for the current command
    always_comb begin
        item       = '0;
        final_byte = 1'b1;
        unique case (i_cmd.kind)
            dmr_pkg::CMD_RA: begin
                final_byte = r_idx == RA_LAST;
                if (r_idx < HDR_END) begin
                    item.tx_byte = hdr_byte(dmr_pkg::TYPE_RA_RES, dmr_pkg::RA_RES_LEN,
                                            r_idx[2:0]);
                end else begin
                    unique case (r_idx)
                        IW'(8):  item.tx_byte = i_cmd.word_a[31:24];
                        IW'(9):  item.tx_byte = i_cmd.word_a[23:16];
                        IW'(10): item.tx_byte = i_cmd.word_a[15:8];
                        IW'(11): item.tx_byte = i_cmd.word_a[7:0];
                        IW'(12): item.tx_byte = dmr_pkg::RA_SUCCESS;
                        default: item.tx_byte = 8'd0;
                    endcase
                end
                item.tx_last = final_byte;
            end
            dmr_pkg::CMD_HDR: begin
                final_byte = r_idx == HDR_LAST;
                if (r_idx < HDR_END) begin
                    item.tx_byte = hdr_byte(dmr_pkg::TYPE_DIAG, i_cmd.word_a, r_idx[2:0]);
                end else begin
                    unique case (r_idx[1:0])
                        2'd0:    item.tx_byte = i_cmd.word_b[15:8];
                        2'd1:    item.tx_byte = i_cmd.word_b[7:0];
                        2'd2:    item.tx_byte = i_cmd.word_b[31:24];
                        default: item.tx_byte = i_cmd.word_b[23:16];
                    endcase
                end
                item.tx_last      = final_byte && i_cmd.last;
                item.tx_truncated = final_byte && i_cmd.trunc;
            end
            default: begin
                item.tx_byte      = i_cmd.word_b[7:0];
                item.tx_last      = i_cmd.last;
                item.tx_truncated = i_cmd.trunc;
            end
        endcase
    end

    assign load       = i_q_valid && (!r_out_valid || !i_tx_stall);
    assign o_pop      = load && final_byte;
    assign o_tx_valid = r_out_valid;
    assign o_tx       = r_out;

    // Output register and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (!r_out_valid || !i_tx_stall) begin
                r_out_valid <= i_q_valid;
            end
            if (load) begin
                r_idx <= final_byte ? '0 : r_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= item;
        end
    end

    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx_valid && o_tx.tx_truncated) |-> o_tx.tx_last)
        else $error("truncated flag without last");

endmodule

`default_nettype wire

// ===== rtl/core/doip_message_responder_top.sv =====
// DoIP message responder. Received packet bytes come in on the rx channel at up to one per
// cycle; the front classifies each byte in the cycle it is taken and queues at most one
// response command for it. The back expands queued commands into response bytes at one
// per cycle unless tx stalls, through a registered output: a routing activation response
// is 17 bytes, an echo header with swapped addresses is 12 bytes, each further echoed byte
// is one. The first response byte passes through the command queue and the output register.
// The rx channel stalls only in reset or while the four-entry queue is full, when responses
// back up behind a slow or stalled tx side. gateway_address may be written only while idle.
`default_nettype none

module doip_message_responder_top (
    input  wire                  logic        i_clk,
    input  wire                  logic        i_rst_n,
    input  wire                  logic        i_rx_valid,
    input  wire dmr_pkg::t_rx_item            i_rx,
    output logic                              o_rx_stall,
    output logic                              o_tx_valid,
    output dmr_pkg::t_tx_item                 o_tx,
    input  wire                  logic        i_tx_stall,
    input  wire                  logic        i_cfg_wr_en,
    input  wire                  logic [15:0] i_cfg_wr_data
);

    logic [15:0]   r_gateway;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    dmr_pkg::t_cmd push_cmd;
    dmr_pkg::t_cmd head_cmd;

    // Gateway address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway <= dmr_pkg::GW_RESET;
        end else if (i_cfg_wr_en) begin
            r_gateway <= i_cfg_wr_data;
        end
    end

    dmr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx       (i_rx),
        .o_rx_stall (o_rx_stall),
        .i_gateway  (r_gateway),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    dmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    dmr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_tx_valid (o_tx_valid),
        .o_tx       (o_tx),
        .i_tx_stall (i_tx_stall)
    );

endmodule

`default_nettype wire

// ===== tb/tb_doip_message_responder_top.sv =====
`default_nettype none

module tb_doip_message_responder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_BYTES    = 16;
    localparam int DIR_ROWS       = 26;
    localparam int NO_CHECK       = -1;

    // Packet state of the predictor
    typedef enum logic [1:0] {MODE_IDLE, MODE_RA, MODE_ECHO} t_pkt_mode;

    // One planned rx transaction and, where obvious, the number of response bytes it causes
    typedef struct {
        dmr_pkg::t_rx_item item;
        int                n_resp;
    } t_rx_plan;

    typedef struct {
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       new_session;
        int         n_resp;
    } t_dir_row;

    // DUT signals
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_rx_valid    = 1'b0;
    dmr_pkg::t_rx_item i_rx          = '0;
    logic              o_rx_stall;
    logic              o_tx_valid;
    dmr_pkg::t_tx_item o_tx;
    logic              i_tx_stall    = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [15:0]       i_cfg_wr_data = '0;

    // Stimulus and expected response bytes
    t_rx_plan          rx_plan[$];
    dmr_pkg::t_tx_item resp_q[$];
    int                cur_n_resp    = NO_CHECK;

    // Predictor state
    logic [15:0]       gw_addr       = dmr_pkg::GW_RESET;
    int                pkt_pos       = 0;
    logic [55:0]       hdr_bytes     = '0;
    logic [31:0]       dec_len       = '0;
    t_pkt_mode         pkt_mode      = MODE_IDLE;
    logic [31:0]       addr_pair     = '0;
    logic [15:0]       tester_addr   = '0;
    logic              routed        = 1'b0;

    // Idling per phase, in percent
    int                send_idle_pct = 0;
    int                stall_pct     = 0;

    int                err_count     = 0;
    int                rx_count      = 0;
    int                tx_count      = 0;
    int                pkt_count     = 0;
    int                planned       = 0;
    int                quiet_cycles  = 0;

    // Directed packets: a short one, an activation, an echo cut short with the
    // largest declared length
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 0}, '{8'hFF, 1'b1, 1'b0, 0},
        '{8'h02, 1'b0, 1'b1, 0}, '{8'hFD, 1'b0, 1'b0, 0},
        '{8'h00, 1'b0, 1'b0, 0}, '{8'h05, 1'b0, 1'b0, 0},
        '{8'h00, 1'b0, 1'b0, 0}, '{8'h00, 1'b0, 1'b0, 0},
        '{8'h00, 1'b0, 1'b0, 0}, '{8'h07, 1'b0, 1'b0, 0},
        '{8'h0E, 1'b0, 1'b0, 0}, '{8'h80, 1'b1, 1'b0, 17},
        '{8'h02, 1'b0, 1'b0, 0}, '{8'hFD, 1'b0, 1'b0, 0},
        '{8'h80, 1'b0, 1'b0, 0}, '{8'h01, 1'b0, 1'b0, 0},
        '{8'hFF, 1'b0, 1'b0, 0}, '{8'hFF, 1'b0, 1'b0, 0},
        '{8'hFF, 1'b0, 1'b0, 0}, '{8'hFF, 1'b0, 1'b0, 0},
        '{8'h0E, 1'b0, 1'b0, 0}, '{8'h80, 1'b0, 1'b0, 0},
        '{8'h00, 1'b0, 1'b0, 0}, '{8'h01, 1'b0, 1'b0, 12},
        '{8'hAA, 1'b0, 1'b0, 1}, '{8'h55, 1'b1, 1'b0, 1}
    };

    doip_message_responder_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .i_rx          (i_rx),
        .o_rx_stall    (o_rx_stall),
        .o_tx_valid    (o_tx_valid),
        .o_tx          (o_tx),
        .i_tx_stall    (i_tx_stall),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void note_failure(string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void queue_resp(logic [7:0] b, logic last, logic trunc);
        dmr_pkg::t_tx_item r;
        r.tx_byte      = b;
        r.tx_last      = last;
        r.tx_truncated = trunc;
        resp_q.push_back(r);
    endfunction

    function automatic void queue_resp_header(logic [15:0] ptype, logic [31:0] len);
        queue_resp(dmr_pkg::DOIP_VERSION, 1'b0, 1'b0);
        queue_resp(~dmr_pkg::DOIP_VERSION, 1'b0, 1'b0);
        queue_resp(ptype[15:8], 1'b0, 1'b0);
        queue_resp(ptype[7:0], 1'b0, 1'b0);
        queue_resp(len[31:24], 1'b0, 1'b0);
        queue_resp(len[23:16], 1'b0, 1'b0);
        queue_resp(len[15:8], 1'b0, 1'b0);
        queue_resp(len[7:0], 1'b0, 1'b0);
    endfunction

    function automatic void clear_packet_state();
        pkt_pos   = 0;
        hdr_bytes = '0;
        dec_len   = '0;
        pkt_mode  = MODE_IDLE;
        addr_pair = '0;
    endfunction

    // Predictor: works out the response bytes of one accepted rx byte
    function automatic int respond_to_byte(dmr_pkg::t_rx_item it);
        int          p;
        int          base_count;
        logic [7:0]  b;
        logic [31:0] len;
        logic [31:0] a;
        logic        at_end;
        logic        at_cap;
        base_count = resp_q.size();
        b          = it.rx_byte;
        if (it.new_session) begin
            routed      = 1'b0;
            tester_addr = '0;
            clear_packet_state();
        end
        p = pkt_pos;
        if (p < dmr_pkg::MAX_PACKET_BYTES) begin
            if (p < 7) begin
                hdr_bytes = {hdr_bytes[47:0], b};
            end else if (p == 7) begin
                len      = {hdr_bytes[23:0], b};
                dec_len  = len;
                pkt_mode = MODE_IDLE;
                if (hdr_bytes[55:48] == dmr_pkg::DOIP_VERSION) begin
                    if (hdr_bytes[39:24] == dmr_pkg::TYPE_RA_REQ &&
                        len >= dmr_pkg::RA_MIN_LEN) begin
                        pkt_mode = MODE_RA;
                    end else if (hdr_bytes[39:24] == dmr_pkg::TYPE_DIAG && routed &&
                                 len >= dmr_pkg::DIAG_MIN_LEN) begin
                        pkt_mode = MODE_ECHO;
                    end
                end
            end else if (pkt_mode == MODE_RA) begin
                if (p == 8) begin
                    addr_pair = {24'd0, b};
                end else begin
                    // Response goes out on payload byte 1, rest of packet ignored
                    tester_addr = {addr_pair[7:0], b};
                    queue_resp_header(dmr_pkg::TYPE_RA_RES, dmr_pkg::RA_RES_LEN);
                    queue_resp(tester_addr[15:8], 1'b0, 1'b0);
                    queue_resp(tester_addr[7:0], 1'b0, 1'b0);
                    queue_resp(gw_addr[15:8], 1'b0, 1'b0);
                    queue_resp(gw_addr[7:0], 1'b0, 1'b0);
                    queue_resp(dmr_pkg::RA_SUCCESS, 1'b0, 1'b0);
                    queue_resp(8'h00, 1'b0, 1'b0);
                    queue_resp(8'h00, 1'b0, 1'b0);
                    queue_resp(8'h00, 1'b0, 1'b0);
                    queue_resp(8'h00, 1'b1, 1'b0);
                    routed   = 1'b1;
                    pkt_mode = MODE_IDLE;
                end
            end else if (pkt_mode == MODE_ECHO) begin
                if (p < 11) begin
                    addr_pair = {addr_pair[23:0], b};
                end else if (p == 11) begin
                    // Header plus swapped addresses in one go
                    a         = {addr_pair[23:0], b};
                    addr_pair = a;
                    queue_resp_header(dmr_pkg::TYPE_DIAG, dec_len);
                    queue_resp(a[15:8], 1'b0, 1'b0);
                    queue_resp(a[7:0], 1'b0, 1'b0);
                    queue_resp(a[31:24], 1'b0, 1'b0);
                    queue_resp(a[23:16], it.rx_last, it.rx_last);
                    if (it.rx_last) begin
                        pkt_mode = MODE_IDLE;
                    end
                end else begin
                    at_end = (dec_len == 32'(p - 7));
                    at_cap = (p == dmr_pkg::MAX_PACKET_BYTES - 1);
                    if (at_end || it.rx_last || at_cap) begin
                        queue_resp(b, 1'b1, !at_end);
                        pkt_mode = MODE_IDLE;
                    end else begin
                        queue_resp(b, 1'b0, 1'b0);
                    end
                end
            end
        end
        if (it.rx_last) begin
            clear_packet_state();
        end else if (pkt_pos < dmr_pkg::MAX_PACKET_BYTES) begin
            pkt_pos++;
        end
        return resp_q.size() - base_count;
    endfunction

    function automatic void plan_byte(logic [7:0] b, logic last, logic ns, int n_resp);
        t_rx_plan e;
        e.item.rx_byte     = b;
        e.item.rx_last     = last;
        e.item.new_session = ns;
        e.n_resp           = n_resp;
        rx_plan.push_back(e);
        planned++;
    endfunction

    // Random packet: mostly well-formed activations and echoes, some broken or noise
    task automatic plan_packet();
        int          kind;
        int          n_pay;
        int          cap;
        int          r;
        int          i;
        int          n_all;
        logic        ns;
        logic        is_ra;
        logic [15:0] ptype;
        logic [31:0] len;
        logic [7:0]  hdr [8];
        kind = $urandom_range(0, 99);
        ns   = ($urandom_range(0, 99) < 8);
        pkt_count++;
        if (kind < 70) begin
            is_ra = (kind < 30);
            if (is_ra) begin
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) :
                                                      $urandom_range(7, 20);
                n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) :
                                                      $urandom_range(2, 9);
                ptype = dmr_pkg::TYPE_RA_REQ;
            end else begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    len = $urandom_range(0, 4);
                end else if (r == 1) begin
                    len = $urandom;
                end else begin
                    len = $urandom_range(5, 14);
                end
                cap = (len > 14) ? 14 : int'(len);
                r   = $urandom_range(0, 9);
                if (r < 6) begin
                    n_pay = cap;
                end else if (r < 8) begin
                    n_pay = $urandom_range(0, cap);
                end else begin
                    n_pay = cap + $urandom_range(1, 3);
                end
                ptype = dmr_pkg::TYPE_DIAG;
            end
            if ($urandom_range(0, 11) == 0) begin
                ptype = 16'($urandom);
            end
            hdr[0] = ($urandom_range(0, 11) == 0) ? 8'($urandom) : dmr_pkg::DOIP_VERSION;
            hdr[1] = ($urandom_range(0, 7) == 0) ? 8'($urandom) : ~dmr_pkg::DOIP_VERSION;
            hdr[2] = ptype[15:8];
            hdr[3] = ptype[7:0];
            hdr[4] = len[31:24];
            hdr[5] = len[23:16];
            hdr[6] = len[15:8];
            hdr[7] = len[7:0];
            n_all  = 8 + n_pay;
            for (i = 0; i < n_all; i++) begin
                plan_byte((i < 8) ? hdr[i] : 8'($urandom), (i == n_all - 1),
                          (i == 0) && ns, NO_CHECK);
            end
        end else if (kind < 85) begin
            // Broken header, often short
            n_all = $urandom_range(1, 12);
            for (i = 0; i < n_all; i++) begin
                plan_byte((i == 0 && $urandom_range(0, 1)) ? dmr_pkg::DOIP_VERSION :
                                                             8'($urandom),
                          (i == n_all - 1), (i == 0) && ns, NO_CHECK);
            end
        end else begin
            // Noise: random bytes and session flags anywhere
            n_all = $urandom_range(1, 12);
            for (i = 0; i < n_all; i++) begin
                plan_byte(8'($urandom), (i == n_all - 1),
                          ($urandom_range(0, 9) == 0), NO_CHECK);
            end
        end
    endtask

    task automatic plan_random_phase();
        int start;
        start = planned;
        while (planned - start < PHASE_BYTES) begin
            plan_packet();
        end
    endtask

    task automatic wait_idle();
        while (rx_plan.size() != 0 || i_rx_valid || resp_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gateway(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        gw_addr = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    // rx side: predict on each accepted transaction, then present the next one
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && !o_rx_stall) begin
                rx_count++;
                n = respond_to_byte(i_rx);
                if (cur_n_resp != NO_CHECK && n != cur_n_resp) begin
                    note_failure($sformatf("rx byte %0d (0x%02h): expected %0d response bytes, predicted %0d",
                                           rx_count, i_rx.rx_byte, cur_n_resp, n));
                end
            end
            if (!i_rx_valid || !o_rx_stall) begin
                if (rx_plan.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_rx       <= rx_plan[0].item;
                    cur_n_resp <= rx_plan[0].n_resp;
                    void'(rx_plan.pop_front());
                    i_rx_valid <= 1'b1;
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // tx side: compare each accepted transaction with the oldest expected byte
    always @(posedge i_clk) begin
        dmr_pkg::t_tx_item want;
        if (!i_rst_n) begin
            i_tx_stall <= 1'b0;
        end else begin
            if (o_tx_valid && !i_tx_stall) begin
                tx_count++;
                if (resp_q.size() == 0) begin
                    note_failure($sformatf("tx byte %0d: unexpected byte=%02h last=%0b trunc=%0b",
                                           tx_count, o_tx.tx_byte, o_tx.tx_last,
                                           o_tx.tx_truncated));
                end else begin
                    want = resp_q.pop_front();
                    if (o_tx.tx_byte !== want.tx_byte || o_tx.tx_last !== want.tx_last ||
                        o_tx.tx_truncated !== want.tx_truncated) begin
                        note_failure($sformatf("tx byte %0d: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                               tx_count, want.tx_byte, want.tx_last,
                                               want.tx_truncated, o_tx.tx_byte,
                                               o_tx.tx_last, o_tx.tx_truncated));
                    end
                end
            end
            i_tx_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_rx_valid && !o_rx_stall) || (o_tx_valid && !i_tx_stall))) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int i;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 0: directed table, then random; no idling, reset gateway
        for (i = 0; i < DIR_ROWS; i++) begin
            plan_byte(dir_rows[i].rx_byte, dir_rows[i].rx_last, dir_rows[i].new_session,
                      dir_rows[i].n_resp);
        end
        plan_random_phase();
        wait_idle();

        // Phase 1: sender idles
        write_gateway(16'h0000);
        send_idle_pct = 65;
        stall_pct     = 0;
        plan_random_phase();
        wait_idle();

        // Phase 2: receiver stalls
        write_gateway(16'hFFFF);
        send_idle_pct = 0;
        stall_pct     = 65;
        plan_random_phase();
        wait_idle();

        // Phase 3: both idle now and then
        write_gateway(16'($urandom));
        send_idle_pct = 19;
        stall_pct     = 19;
        plan_random_phase();
        wait_idle();

        $display("Covered %0d packets, %0d rx bytes and %0d checked response bytes,",
                 pkt_count, rx_count, tx_count);
        $display("over four idling phases and four gateway addresses; %0d mismatches.",
                 err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/dmr_pkg.sv
rtl/core/dmr_front.sv
rtl/core/dmr_queue.sv
rtl/core/dmr_back.sv
rtl/core/doip_message_responder_top.sv
tb/tb_doip_message_responder_top.sv
